@@ rtl/core/mei_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape iterator package
// Shared constants, register indexes, the iteration token and helpers.
// ----------------------------------------------------------------------------
package mei_pkg;

   localparam int FRAC_BITS_DEF  = 28;
   localparam int ITER_BITS_DEF  = 16;
   localparam int CELL_COUNT_DEF = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER      = 3'd5;

   localparam logic [12:0] CANVAS_WIDTH_RST  = 13'd640;
   localparam logic [12:0] CANVAS_HEIGHT_RST = 13'd480;
   localparam logic [31:0] CENTER_X_RST      = 32'd0;
   localparam logic [31:0] CENTER_Y_RST      = 32'd0;
   localparam logic [30:0] PIXEL_STEP_RST    = 31'd2236962;
   localparam logic [15:0] MAX_ITER_RST      = 16'd256;

   typedef struct packed {
      logic               valid;
      logic               done;
      logic               escaped;
      logic [15:0]        iter;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [31:0]        mag;
   } token_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = 32'(v);
      end
   endfunction

endpackage

@@ rtl/core/mandelbrot_escape_iterate_top.sv @@
// A request first has its point mapped in states ST_MUL and ST_LOAD, then its token
// circles a ring of CELL_COUNT cells, each with a multiply stage and an update stage,
// until it is done and the output register is free to take the result.
// One pixel is in flight at a time; the input is ready again at the edge that
// registers the result. A full output register sends the token around the ring again.
// Reset is synchronous; it empties the ring and restores the CSR registers to defaults.
// ----------------------------------------------------------------------------
// Mandelbrot escape iterator top level
// Maps a pixel to a point c and iterates it through a ring of iteration cells.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iterate_top #(
   parameter int FRAC_BITS  = mei_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS  = mei_pkg::ITER_BITS_DEF,
   parameter int CELL_COUNT = mei_pkg::CELL_COUNT_DEF,
   localparam int RSP_W     = ((ITER_BITS + 32 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata fields: col [11:0], row [23:12].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   // tdata fields: iterations, then final_mag_sq (32 bits).
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata,
   // tuser fields: escaped [0].
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [mei_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mei_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_RUN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [12:0]        width_ff, height_ff;
   logic signed [31:0] center_x_ff, center_y_ff;
   logic [30:0]        step_ff;
   logic [15:0]        max_iter_ff;

   logic [11:0]        col_ff, row_ff;
   logic signed [14:0] dx, dy;
   logic signed [46:0] px_in, py_in, px_ff, py_ff;

   logic                 rsp_valid_ff;
   logic [ITER_BITS-1:0] rsp_iter_ff;
   logic                 rsp_esc_ff;
   logic [31:0]          rsp_mag_ff;

   mei_pkg::token_type ring [0:CELL_COUNT];
   mei_pkg::token_type feed;
   mei_pkg::token_type tail;
   logic               capture;

   assign tail       = ring[CELL_COUNT];
   assign req_tready = (state_ff == ST_IDLE);
   assign capture    = (state_ff == ST_RUN) && tail.valid && tail.done &&
                       (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= mei_pkg::CANVAS_WIDTH_RST;
         height_ff   <= mei_pkg::CANVAS_HEIGHT_RST;
         center_x_ff <= mei_pkg::CENTER_X_RST;
         center_y_ff <= mei_pkg::CENTER_Y_RST;
         step_ff     <= mei_pkg::PIXEL_STEP_RST;
         max_iter_ff <= mei_pkg::MAX_ITER_RST;
      end else if (csr_we) begin
         case (csr_index)
            mei_pkg::CSR_CANVAS_WIDTH:  width_ff    <= csr_wdata[12:0];
            mei_pkg::CSR_CANVAS_HEIGHT: height_ff   <= csr_wdata[12:0];
            mei_pkg::CSR_CENTER_X:      center_x_ff <= csr_wdata;
            mei_pkg::CSR_CENTER_Y:      center_y_ff <= csr_wdata;
            mei_pkg::CSR_PIXEL_STEP:    step_ff     <= csr_wdata[30:0];
            mei_pkg::CSR_MAX_ITER:      max_iter_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign dx    = $signed({2'b00, col_ff, 1'b0}) - $signed({2'b00, width_ff});
   assign dy    = $signed({2'b00, height_ff}) - $signed({2'b00, row_ff, 1'b0});
   assign px_in = 47'(dx) * $signed({16'd0, step_ff});
   assign py_in = 47'(dy) * $signed({16'd0, step_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_RUN;
         ST_RUN:  if (capture) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         col_ff <= req_tdata[11:0];
         row_ff <= req_tdata[23:12];
      end
      if (state_ff == ST_MUL) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (capture) begin
         rsp_iter_ff <= ITER_BITS'(tail.iter);
         rsp_esc_ff  <= tail.escaped;
         rsp_mag_ff  <= tail.mag;
      end
   end

   always_comb begin
      feed = tail;
      if (capture) begin
         feed.valid = 1'b0;
      end
      if (state_ff == ST_LOAD) begin
         feed.valid   = 1'b1;
         feed.done    = 1'b0;
         feed.escaped = 1'b0;
         feed.iter    = '0;
         feed.x       = '0;
         feed.y       = '0;
         feed.mag     = '0;
         feed.cx      = mei_pkg::sat32(64'(center_x_ff) + 64'(px_ff >>> 1));
         feed.cy      = mei_pkg::sat32(64'(center_y_ff) + 64'(py_ff >>> 1));
      end
   end

   assign ring[0] = feed;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      mei_cell #(
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .max_iter(max_iter_ff),
         .tok_in  (ring[i]),
         .tok_out (ring[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_mag_ff, rsp_iter_ff});
   assign rsp_tuser  = rsp_esc_ff;

endmodule

@@ rtl/core/mei_cell.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape iterator cell
// One iteration of z = z*z + c: a multiply stage, then the update stage.
// ----------------------------------------------------------------------------
module mei_cell #(
   parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        max_iter,
   input  mei_pkg::token_type tok_in,
   output mei_pkg::token_type tok_out
);

   localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;
   localparam int SHR = (FRAC_BITS >= 26) ? FRAC_BITS - 26 : 0;
   localparam int SHL = (FRAC_BITS < 26) ? 26 - FRAC_BITS : 0;

   mei_pkg::token_type a_ff;
   mei_pkg::token_type b_ff;
   logic signed [63:0] xx_ff, yy_ff, xy_ff;
   logic signed [63:0] xx_in, yy_in, xy_in;
   logic signed [63:0] xs, ys;
   logic signed [63:0] xx, yy, mag, nx_w, ny_w;
   logic [63:0]        fmag;
   logic               stop;

   assign xs    = 64'(a_ff.x);
   assign ys    = 64'(a_ff.y);
   assign xx_in = xs * xs;
   assign yy_in = ys * ys;
   assign xy_in = xs * ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         a_ff <= tok_in;
         b_ff <= a_ff;
      end
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      xy_ff <= xy_in;
   end

   always_comb begin
      xx   = xx_ff >>> FRAC_BITS;
      yy   = yy_ff >>> FRAC_BITS;
      mag  = xx + yy;
      stop = (mag > FOUR) || (b_ff.iter >= max_iter);
      nx_w = xx - yy + 64'(b_ff.cx);
      ny_w = (xy_ff >>> (FRAC_BITS - 1)) + 64'(b_ff.cy);
      fmag = (64'(unsigned'(mag)) >> SHR) << SHL;
      tok_out = b_ff;
      if (b_ff.valid && !b_ff.done) begin
         if (stop) begin
            tok_out.done    = 1'b1;
            tok_out.escaped = (b_ff.iter < max_iter);
            tok_out.mag     = (fmag > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(fmag);
         end else begin
            tok_out.x    = mei_pkg::sat32(nx_w);
            tok_out.y    = mei_pkg::sat32(ny_w);
            tok_out.iter = b_ff.iter + 16'd1;
         end
      end
   end

endmodule

@@ rtl/core/mei_checker.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape iterator checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module mei_checker #(
   parameter int ITER_BITS = mei_pkg::ITER_BITS_DEF,
   parameter int RSP_W     = ((ITER_BITS + 32 + 7) / 8) * 8
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [31:0]                    req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [RSP_W-1:0]               rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           csr_we,
   input logic [mei_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [mei_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only one pixel is worked on at a time.
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a pixel is in flight");

   // An escaped point ends with a magnitude above four.
   a_escape_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[ITER_BITS +: 32] >= 32'h1000_0000)
      else $error("escaped result with small magnitude");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind mandelbrot_escape_iterate_top mei_checker #(.ITER_BITS(ITER_BITS)) u_mei_checker (.*);

@@ test/tb_mandelbrot_escape_iterate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape iterator testbench
// Streams canvas pixels into the iterator under several view settings and
// checks every iteration count, escape flag and final squared magnitude
// against a cycle-free predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_iterate_top;

   localparam int     FRAC             = mei_pkg::FRAC_BITS_DEF;
   localparam int     RSP_W            = ((mei_pkg::ITER_BITS_DEF + 32 + 7) / 8) * 8;
   localparam longint CYCLE_LIMIT      = 2000000;
   localparam longint S32_MAX          = 64'sd2147483647;
   localparam longint S32_MIN          = -64'sd2147483648;
   localparam longint ESCAPE_RADIUS_SQ = longint'(4) <<< FRAC;
   localparam longint MAG_FULL_SCALE   = 64'sd4294967295;
   localparam int     RANDOM_PHASES    = 6;
   localparam int     PIXELS_PER_PHASE = 88;
   localparam int     HOLD_CYCLES      = 1500;

   localparam logic [mei_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [mei_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] col;
   } pixel_type;

   typedef struct packed {
      logic [15:0] iterations;
      logic        escaped;
      logic [31:0] final_mag_sq;
   } escape_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // tdata fields: col [11:0], row [23:12].
   logic [31:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // tdata fields: iterations [15:0], final_mag_sq [47:16].
   logic [RSP_W-1:0]               rsp_tdata;
   // tuser fields: escaped [0].
   logic                           rsp_tuser;
   logic                           csr_we     = 1'b0;
   logic [mei_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [mei_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   longint cfg_width      = 640;
   longint cfg_height     = 480;
   longint cfg_center_x   = 0;
   longint cfg_center_y   = 0;
   longint cfg_step       = 2236962;
   longint cfg_max_iter   = 256;

   pixel_type  pixel_queue[$];
   escape_type predicted_escapes[$];
   pixel_type  offered_px;
   bit         steady       = 1'b0;
   int         rsp_count    = 0;
   int         sent_count   = 0;
   int         queued_count = 0;
   int         error_count  = 0;
   int         phase_count  = 0;
   int         hold_left    = 0;
   bit         hold_done    = 1'b0;
   longint     cycle_count  = 0;

   mandelbrot_escape_iterate_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) begin
         return S32_MAX;
      end else if (v < S32_MIN) begin
         return S32_MIN;
      end
      return v;
   endfunction

   function automatic escape_type compute_escape(input pixel_type px);
      longint     re_c;
      longint     im_c;
      longint     re_z;
      longint     im_z;
      longint     re_sq;
      longint     im_sq;
      longint     mag_sq;
      longint     re_next;
      longint     count;
      logic       done;
      escape_type res;
      re_c = clamp32(cfg_center_x + (((2 * longint'(px.col) - cfg_width) * cfg_step) >>> 1));
      im_c = clamp32(cfg_center_y + (((cfg_height - 2 * longint'(px.row)) * cfg_step) >>> 1));
      re_z = 0;
      im_z = 0;
      count = 0;
      do begin
         re_sq = (re_z * re_z) >>> FRAC;
         im_sq = (im_z * im_z) >>> FRAC;
         mag_sq = re_sq + im_sq;
         done = (mag_sq > ESCAPE_RADIUS_SQ) || (count >= cfg_max_iter);
         if (!done) begin
            re_next = clamp32(re_sq - im_sq + re_c);
            im_z = clamp32(((re_z * im_z) >>> (FRAC - 1)) + im_c);
            re_z = re_next;
            count++;
         end
      end while (!done);
      mag_sq = mag_sq >>> (FRAC - 26);
      res.iterations = count[15:0];
      res.escaped = (count < cfg_max_iter);
      res.final_mag_sq = (mag_sq > MAG_FULL_SCALE) ? 32'hFFFF_FFFF : mag_sq[31:0];
      return res;
   endfunction

   task automatic write_csr(input logic [mei_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mei_pkg::CSR_CANVAS_WIDTH:  cfg_width = longint'(value[12:0]);
         mei_pkg::CSR_CANVAS_HEIGHT: cfg_height = longint'(value[12:0]);
         mei_pkg::CSR_CENTER_X:      cfg_center_x = longint'($signed(value));
         mei_pkg::CSR_CENTER_Y:      cfg_center_y = longint'($signed(value));
         mei_pkg::CSR_PIXEL_STEP:    cfg_step = longint'(value[30:0]);
         mei_pkg::CSR_MAX_ITER:      cfg_max_iter = longint'(value[15:0]);
         default: ;
      endcase
   endtask

   task automatic add_pixel(input int col, input int row);
      pixel_type px;
      px.col = col[11:0];
      px.row = row[11:0];
      pixel_queue.push_back(px);
      queued_count++;
   endtask

   task automatic drain();
      while (rsp_count != queued_count) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      phase_count++;
   endtask

   function automatic logic [12:0] pick_size();
      int mode;
      mode = $urandom_range(0, 9);
      case (mode)
         0: return 13'd0;
         1: return 13'h1FFF;
         2: return 13'd1;
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic int pick_coord(input longint span);
      if (span >= 1 && span <= 4096 && $urandom_range(0, 1) == 1) begin
         return $urandom_range(0, int'(span) - 1);
      end
      return $urandom_range(0, 4095);
   endfunction

   task automatic run_random_phase(input int count, input int iter_cap);
      logic [31:0] junk;
      logic [12:0] w;
      logic [12:0] h;
      logic [31:0] step;
      logic [15:0] limit;
      int          mode;
      int          i;
      junk = $urandom;
      w = pick_size();
      h = pick_size();
      write_csr(mei_pkg::CSR_CANVAS_WIDTH, {junk[31:13], w});
      junk = $urandom;
      write_csr(mei_pkg::CSR_CANVAS_HEIGHT, {junk[31:13], h});
      if ($urandom_range(0, 7) == 0) begin
         write_csr(mei_pkg::CSR_CENTER_X, $urandom);
         write_csr(mei_pkg::CSR_CENTER_Y, $urandom);
      end else begin
         write_csr(mei_pkg::CSR_CENTER_X,
                   32'($urandom_range(0, 805306368)) - 32'd536870912);
         write_csr(mei_pkg::CSR_CENTER_Y,
                   32'($urandom_range(0, 671088640)) - 32'd335544320);
      end
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         step = $urandom;
      end else if (mode == 1) begin
         step = 32'd0;
      end else begin
         step = 32'd805306368 / ((h == 13'd0) ? 32'd1 : 32'(h)) + 32'($urandom_range(0, 64));
         junk = $urandom;
         step[31] = junk[0];
      end
      write_csr(mei_pkg::CSR_PIXEL_STEP, step);
      limit = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, iter_cap));
      junk = $urandom;
      write_csr(mei_pkg::CSR_MAX_ITER, {junk[31:16], limit});
      for (i = 0; i < count; i++) begin
         add_pixel(pick_coord(cfg_width), pick_coord(cfg_height));
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_escapes.push_back(compute_escape(offered_px));
            sent_count <= sent_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
               offered_px = pixel_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {8'h00, offered_px};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= 60) begin
         rsp_tready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
      end
   end

   always @(posedge clock) begin
      escape_type got;
      escape_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.iterations = rsp_tdata[15:0];
         got.escaped = rsp_tuser;
         got.final_mag_sq = rsp_tdata[47:16];
         if (predicted_escapes.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected result transfer: iter %0d escaped %0b mag %h",
                        got.iterations, got.escaped, got.final_mag_sq);
            end
         end else begin
            want = predicted_escapes.pop_front();
            if (got.iterations !== want.iterations || got.escaped !== want.escaped ||
                got.final_mag_sq !== want.final_mag_sq) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Mismatch on result %0d: expected iter %0d escaped %0b mag %h,",
                           rsp_count, want.iterations, want.escaped, want.final_mag_sq);
                  $display("   got iter %0d escaped %0b mag %h",
                           got.iterations, got.escaped, got.final_mag_sq);
               end
            end
         end
         rsp_count <= rsp_count + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, predicted_escapes.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Default view: far corners saturate the point mapping, the center is inside.
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(4095, 0);
      add_pixel(0, 4095);
      add_pixel(320, 240);
      add_pixel(160, 240);
      add_pixel(12'hAAA, 12'h555);
      add_pixel(12'h555, 12'hAAA);
      drain();

      // A zero iteration limit reports zero iterations and no escape.
      write_csr(mei_pkg::CSR_MAX_ITER, 32'hABCD_0000);
      add_pixel(320, 240);
      add_pixel(0, 0);
      drain();

      // Odd canvas sizes keep the half-pixel offset.
      write_csr(mei_pkg::CSR_CANVAS_WIDTH, 32'd7);
      write_csr(mei_pkg::CSR_CANVAS_HEIGHT, 32'd5);
      write_csr(mei_pkg::CSR_PIXEL_STEP, 32'h0555_5555);
      write_csr(mei_pkg::CSR_CENTER_X, 32'd1);
      write_csr(mei_pkg::CSR_CENTER_Y, 32'hFFFF_FFFF);
      write_csr(mei_pkg::CSR_MAX_ITER, 32'd50);
      add_pixel(0, 0);
      add_pixel(3, 2);
      add_pixel(6, 4);
      add_pixel(1, 3);
      drain();

      // Out-of-range sizes, extreme centers and step; writes to unused indexes.
      write_csr(mei_pkg::CSR_CANVAS_WIDTH, 32'd0);
      write_csr(mei_pkg::CSR_CANVAS_HEIGHT, 32'hFFFF_FFFF);
      write_csr(mei_pkg::CSR_PIXEL_STEP, 32'hFFFF_FFFF);
      write_csr(mei_pkg::CSR_CENTER_X, 32'h7FFF_FFFF);
      write_csr(mei_pkg::CSR_CENTER_Y, 32'h8000_0000);
      write_csr(mei_pkg::CSR_MAX_ITER, 32'd1);
      write_csr(CSR_SPARE_A, 32'h1234_5678);
      write_csr(CSR_SPARE_B, 32'h8765_4321);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(2048, 0);
      drain();

      // Largest iteration limit: one point that never escapes, one that escapes fast.
      write_csr(mei_pkg::CSR_CANVAS_WIDTH, 32'd2);
      write_csr(mei_pkg::CSR_CANVAS_HEIGHT, 32'd2);
      write_csr(mei_pkg::CSR_PIXEL_STEP, 32'd0);
      write_csr(mei_pkg::CSR_CENTER_X, 32'd0);
      write_csr(mei_pkg::CSR_CENTER_Y, 32'd0);
      write_csr(mei_pkg::CSR_MAX_ITER, 32'hFFFF_FFFF);
      add_pixel(1, 1);
      drain();
      write_csr(mei_pkg::CSR_CENTER_X, 32'h2000_0000);
      add_pixel(0, 0);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         steady = (p == 2);
         run_random_phase(PIXELS_PER_PHASE, (p == 4) ? 256 : 40 + 16 * p);
      end
      steady = 1'b0;

      repeat (64) @(posedge clock);
      $display("Ran %0d pixels through %0d register settings, iteration limits 0 to 65535.",
               sent_count, phase_count);
      $display("Included zero and oversize canvases, saturated points and a long output stall.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("Total mismatches: %0d", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
